// File: hdl/y4m_header_parser_macros.svh
// Assertion macros shared by the header parser modules.
`ifndef Y4M_HEADER_PARSER_MACROS_SVH
`define Y4M_HEADER_PARSER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define Y4M_ASSERT_NOW(lbl, cause, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cause) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define Y4M_ASSERT_NEXT(lbl, cause, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cause) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/y4mhp_pkg.sv
// Shared types, constants and string tables of the YUV4MPEG2 header parser.
`default_nettype none
package y4mhp_pkg;

    // Default configuration of the top level
    localparam int TOKEN_MAX_DEF = 16;
    localparam int DIM_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH   = 4;

    // Special bytes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;

    // Bit positions in the found mask
    localparam int BIT_W = 0;
    localparam int BIT_H = 1;
    localparam int BIT_F = 2;
    localparam int BIT_I = 3;
    localparam int BIT_A = 4;
    localparam int BIT_C = 5;

    // Reference strings: magic, then rate, interlace, aspect and chroma lists
    localparam int NUM_STR   = 20;
    localparam int STR_CHARS = 11;
    localparam int STR_BITS  = 8 * STR_CHARS;
    localparam int IDX_MAGIC  = 0;
    localparam int IDX_RATE   = 1;
    localparam int IDX_INTER  = 6;
    localparam int IDX_ASPECT = 10;
    localparam int IDX_CHROMA = 15;
    localparam int NUM_RATE   = 5;
    localparam int NUM_INTER  = 4;
    localparam int NUM_ASPECT = 5;
    localparam int NUM_CHROMA = 5;
    localparam logic [2:0] CHROMA_DEF = 3'd2;

    localparam logic [STR_BITS-1:0] STR_TEXT [NUM_STR] = '{
        "YUV4MPEG2",
        "F30:1", "F25:1", "F24:1", "F30000:1001", "F24000:1001",
        "Ip", "It", "Ib", "Im",
        "A0:0", "A1:1", "A4:3", "A4:5", "A32:27",
        "C420jpeg", "C420paldv", "C420", "C422", "C444"
    };
    localparam int STR_LEN [NUM_STR] = '{
        9,
        5, 5, 5, 11, 11,
        2, 2, 2, 2,
        4, 4, 4, 4, 6,
        8, 9, 4, 4, 4
    };

    // Character p of string k, zero past its end
    function automatic logic [7:0] str_char(input int k, input logic [3:0] p);
        int base;
        base = 8 * (STR_LEN[k] - 1 - int'(p));
        if (int'(p) < STR_LEN[k]) begin
            return STR_TEXT[k][base +: 8];
        end
        return 8'h00;
    endfunction

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_tok;
        logic       ends_tok;
        logic       ends_line;
        logic       is_digit;
        logic [3:0] digit;
    } cmd_t;

    // One parsed header line
    typedef struct packed {
        logic        header_ok;
        logic        magic_ok;
        logic [5:0]  found_mask;
        logic [2:0]  chroma_code;
        logic [2:0]  aspect_code;
        logic [1:0]  interlace_code;
        logic [2:0]  rate_code;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
    } res_t;

endpackage
`default_nettype wire

// File: hdl/y4mhp_front.sv
// Front end: accepts header bytes and classifies them for the parser.
`default_nettype none
module y4mhp_front (
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [7:0]      s_axis_tdata,
    input  wire logic            s_axis_tlast,
    input  wire logic            q_full,
    output logic                 q_push,
    output y4mhp_pkg::cmd_t      q_cmd
);
    import y4mhp_pkg::*;

    logic is_space;
    logic is_nl;

    // Take a byte whenever the queue has room
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Classify the byte
    always_comb begin
        is_space          = (s_axis_tdata == CH_SPACE);
        is_nl             = (s_axis_tdata == CH_NL);
        q_cmd.data        = s_axis_tdata;
        q_cmd.is_tok      = !is_space && !is_nl;
        q_cmd.ends_tok    = is_space || is_nl || s_axis_tlast;
        q_cmd.ends_line   = is_nl || s_axis_tlast;
        q_cmd.is_digit    = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
        q_cmd.digit       = s_axis_tdata[3:0];
    end

endmodule
`default_nettype wire

// File: hdl/y4mhp_queue.sv
// Short queue of classified bytes between front and back.
`default_nettype none
`include "y4m_header_parser_macros.svh"
module y4mhp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire y4mhp_pkg::cmd_t  push_cmd,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output y4mhp_pkg::cmd_t       head_cmd
);
    import y4mhp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = slot_reg[rptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    `Y4M_ASSERT_NOW(a_q_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue over depth")
    `Y4M_ASSERT_NEXT(a_q_grow, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue grow")
    `Y4M_ASSERT_NEXT(a_q_shrink, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue shrink")

endmodule
`default_nettype wire

// File: hdl/y4mhp_back.sv
// Back end: tokenizes classified bytes, parses tags and holds the line result.
`default_nettype none
`include "y4m_header_parser_macros.svh"
module y4mhp_back #(
    parameter int TOKEN_MAX = y4mhp_pkg::TOKEN_MAX_DEF,
    parameter int DIM_BITS  = y4mhp_pkg::DIM_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    input  wire y4mhp_pkg::cmd_t  q_cmd,
    output logic                  q_pop,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output y4mhp_pkg::res_t       res
);
    import y4mhp_pkg::*;

    localparam int LEN_W = $clog2(TOKEN_MAX + 2);
    localparam int ACC_W = DIM_BITS + 4;

    // Line state
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                index_reg, index_next;
    logic [7:0]          first_reg, first_next;
    logic [NUM_STR-1:0]  flags_reg, flags_next;
    logic [DIM_BITS-1:0] acc_reg, acc_next;
    logic                live_reg, live_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [2:0]          rate_reg, rate_next;
    logic [1:0]          inter_reg, inter_next;
    logic [2:0]          aspect_reg, aspect_next;
    logic [2:0]          chroma_reg, chroma_next;
    logic [5:0]          seen_reg, seen_next;
    logic [5:0]          tried_reg, tried_next;
    logic                magic_reg, magic_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    // Working values
    logic                len_zero;
    logic [LEN_W-1:0]    len_tok;
    logic [NUM_STR-1:0]  flags_tok;
    logic [NUM_STR-1:0]  match;
    logic [DIM_BITS-1:0] acc_tok;
    logic                live_tok;
    logic [ACC_W-1:0]    acc_ext;
    logic [ACC_W-1:0]    acc_mul;
    logic [7:0]          tag;
    logic                finish;
    logic [5:0]          tag_bit;
    logic                hit_any;
    logic [DIM_BITS-1:0] width_f, height_f;
    logic [2:0]          rate_f, aspect_f, chroma_f;
    logic [1:0]          inter_f;
    logic [5:0]          seen_f, tried_f;
    logic                magic_f, index_f;
    logic [31:0]         width32, height32;

    assign q_pop     = q_valid && (!q_cmd.ends_line || !res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Extend the token by this byte: length, string matches, decimal value
    always_comb begin
        len_zero  = (len_reg == '0);
        len_tok   = len_reg;
        flags_tok = flags_reg;
        acc_tok   = acc_reg;
        live_tok  = live_reg;
        acc_ext   = ACC_W'(acc_reg);
        acc_mul   = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(q_cmd.digit);
        if (q_cmd.is_tok) begin
            if (len_reg <= LEN_W'(TOKEN_MAX)) begin
                len_tok = len_reg + 1'b1;
            end
            for (int k = 0; k < NUM_STR; k++) begin
                flags_tok[k] = (len_zero || flags_reg[k])
                    && (len_reg < LEN_W'(STR_LEN[k]))
                    && (q_cmd.data == str_char(k, len_reg[3:0]));
            end
            if (len_zero) begin
                acc_tok  = '0;
                live_tok = 1'b1;
            end else if (live_reg) begin
                if (q_cmd.is_digit) begin
                    acc_tok = (acc_mul[ACC_W-1:DIM_BITS] != '0) ? {DIM_BITS{1'b1}}
                                                                : acc_mul[DIM_BITS-1:0];
                end else begin
                    live_tok = 1'b0;
                end
            end
        end
        for (int k = 0; k < NUM_STR; k++) begin
            match[k] = flags_tok[k] && (len_tok == LEN_W'(STR_LEN[k]));
        end
    end

    // Close the token: magic check or first occurrence of a tag
    always_comb begin
        tag      = len_zero ? q_cmd.data : first_reg;
        finish   = q_cmd.ends_tok && (len_tok != '0);
        width_f  = width_reg;
        height_f = height_reg;
        rate_f   = rate_reg;
        inter_f  = inter_reg;
        aspect_f = aspect_reg;
        chroma_f = chroma_reg;
        seen_f   = seen_reg;
        tried_f  = tried_reg;
        magic_f  = magic_reg;
        index_f  = index_reg;
        tag_bit  = '0;
        hit_any  = 1'b0;
        case (tag)
            CH_W:    tag_bit[BIT_W] = 1'b1;
            CH_H:    tag_bit[BIT_H] = 1'b1;
            CH_F:    tag_bit[BIT_F] = 1'b1;
            CH_I:    tag_bit[BIT_I] = 1'b1;
            CH_A:    tag_bit[BIT_A] = 1'b1;
            CH_C:    tag_bit[BIT_C] = 1'b1;
            default: tag_bit = '0;
        endcase
        if (finish) begin
            if (!index_reg) begin
                magic_f = match[IDX_MAGIC];
                index_f = 1'b1;
            end else if ((tag_bit & ~tried_reg) != '0) begin
                tried_f = tried_reg | tag_bit;
                if (tag_bit[BIT_W]) begin
                    width_f = acc_tok;
                    hit_any = 1'b1;
                end else if (tag_bit[BIT_H]) begin
                    height_f = acc_tok;
                    hit_any  = 1'b1;
                end else if (tag_bit[BIT_F]) begin
                    for (int i = 0; i < NUM_RATE; i++) begin
                        if (match[IDX_RATE + i]) begin
                            rate_f  = 3'(i);
                            hit_any = 1'b1;
                        end
                    end
                end else if (tag_bit[BIT_I]) begin
                    for (int i = 0; i < NUM_INTER; i++) begin
                        if (match[IDX_INTER + i]) begin
                            inter_f = 2'(i);
                            hit_any = 1'b1;
                        end
                    end
                end else if (tag_bit[BIT_A]) begin
                    for (int i = 0; i < NUM_ASPECT; i++) begin
                        if (match[IDX_ASPECT + i]) begin
                            aspect_f = 3'(i);
                            hit_any  = 1'b1;
                        end
                    end
                end else begin
                    for (int i = 0; i < NUM_CHROMA; i++) begin
                        if (match[IDX_CHROMA + i]) begin
                            chroma_f = 3'(i);
                            hit_any  = 1'b1;
                        end
                    end
                end
                if (hit_any) begin
                    seen_f = seen_reg | tag_bit;
                end
            end
        end
    end

    // Pick next state: hold, advance, or emit the line and clear
    always_comb begin
        width32        = 32'(width_f);
        height32       = 32'(height_f);
        len_next       = len_reg;
        index_next     = index_reg;
        first_next     = first_reg;
        flags_next     = flags_reg;
        acc_next       = acc_reg;
        live_next      = live_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        rate_next      = rate_reg;
        inter_next     = inter_reg;
        aspect_next    = aspect_reg;
        chroma_next    = chroma_reg;
        seen_next      = seen_reg;
        tried_next     = tried_reg;
        magic_next     = magic_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        if (q_pop) begin
            len_next    = q_cmd.ends_tok ? '0 : len_tok;
            index_next  = index_f;
            first_next  = (q_cmd.is_tok && len_zero) ? q_cmd.data : first_reg;
            flags_next  = flags_tok;
            acc_next    = acc_tok;
            live_next   = live_tok;
            width_next  = width_f;
            height_next = height_f;
            rate_next   = rate_f;
            inter_next  = inter_f;
            aspect_next = aspect_f;
            chroma_next = chroma_f;
            seen_next   = seen_f;
            tried_next  = tried_f;
            magic_next  = magic_f;
            if (q_cmd.ends_line) begin
                res_valid_next          = 1'b1;
                res_next.frame_width    = width32[15:0];
                res_next.frame_height   = height32[15:0];
                res_next.rate_code      = rate_f;
                res_next.interlace_code = inter_f;
                res_next.aspect_code    = aspect_f;
                res_next.chroma_code    = chroma_f;
                res_next.found_mask     = seen_f;
                res_next.magic_ok       = magic_f;
                res_next.header_ok      = magic_f && seen_f[BIT_W] && seen_f[BIT_F]
                                          && seen_f[BIT_I] && seen_f[BIT_A];
                len_next    = '0;
                index_next  = 1'b0;
                acc_next    = '0;
                live_next   = 1'b0;
                width_next  = '0;
                height_next = '0;
                rate_next   = '0;
                inter_next  = '0;
                aspect_next = '0;
                chroma_next = CHROMA_DEF;
                seen_next   = '0;
                tried_next  = '0;
                magic_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            index_reg     <= 1'b0;
            live_reg      <= 1'b0;
            acc_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            rate_reg      <= '0;
            inter_reg     <= '0;
            aspect_reg    <= '0;
            chroma_reg    <= CHROMA_DEF;
            seen_reg      <= '0;
            tried_reg     <= '0;
            magic_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            index_reg     <= index_next;
            live_reg      <= live_next;
            acc_reg       <= acc_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            rate_reg      <= rate_next;
            inter_reg     <= inter_next;
            aspect_reg    <= aspect_next;
            chroma_reg    <= chroma_next;
            seen_reg      <= seen_next;
            tried_reg     <= tried_next;
            magic_reg     <= magic_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        flags_reg <= flags_next;
        res_reg   <= res_next;
    end

    `Y4M_ASSERT_NEXT(a_line_clear, q_pop && q_cmd.ends_line,
        len_reg == '0 && seen_reg == '0 && !index_reg && res_valid_reg, "line not cleared")
    `Y4M_ASSERT_NOW(a_ok_magic, res_valid_reg && res_reg.header_ok,
        res_reg.magic_ok && res_reg.found_mask[BIT_W], "header_ok without magic or W")
    `Y4M_ASSERT_NOW(a_seen_tried, 1'b1, (seen_reg & ~tried_reg) == '0,
        "tag found but never tried")

endmodule
`default_nettype wire

// File: hdl/y4m_header_parser.sv
// Top level of the YUV4MPEG2 header line parser.
//
//   Channel  Dir  tdata fields (low bit up)                                tlast
//   s_axis   in   header_byte[7:0]                                         line_end
//   m_axis   out  frame_width[15:0] frame_height[31:16] rate_code[34:32]    -
//                 interlace_code[36:35] aspect_code[39:37] chroma_code[42:40]
//                 found_mask[48:43] magic_ok[49] header_ok[50] zero[55:51]
//
// One byte is taken per cycle while the queue has room; a byte passes the classifier,
// a four-entry queue and the parser. With the queue otherwise empty and no result held,
// a line's last byte is queued, then the registered result raises m_axis_tvalid.
// The parser closes a token and parses its tag in the same cycle as its ending byte.
// A held result stops the parser at the next line-ending byte; the bytes behind it
// fill the queue, and s_axis_tready drops once the queue holds four.
// Reset is synchronous on aresetn low and leaves the parser at the start of a line.
`default_nettype none
module y4m_header_parser #(
    parameter int TOKEN_MAX = y4mhp_pkg::TOKEN_MAX_DEF,
    parameter int DIM_BITS  = y4mhp_pkg::DIM_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // header_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata    // width, height, rate, interlace, aspect,
                                             // chroma, found, magic_ok, header_ok
);
    import y4mhp_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    res_t line_res;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;

    y4mhp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (front_cmd)
    );

    y4mhp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    y4mhp_back #(
        .TOKEN_MAX (TOKEN_MAX),
        .DIM_BITS  (DIM_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (line_res)
    );

    // Pack the result fields, frame_width in the lowest bits
    assign m_axis_tdata = {5'b00000, line_res.header_ok, line_res.magic_ok,
                           line_res.found_mask, line_res.chroma_code, line_res.aspect_code,
                           line_res.interlace_code, line_res.rate_code,
                           line_res.frame_height, line_res.frame_width};

endmodule
`default_nettype wire
